[rtl/rpn_pkg.sv]
// Shared types and constants for the RPN stack evaluator.
package rpn_pkg;

  localparam int unsigned OP_W = 3;
  localparam int unsigned Q_W  = 32;
  localparam int unsigned DEPTH_OUT_W = 8;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_SHOW = 3'd5
  } op_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic       load_in;     // capture input item
    logic       pop_b;       // pop top into b
    logic       pop_a;       // pop top into a
    logic       rd_issue;    // start memory read at sp-1
    logic       arith;       // compute add/sub/mul result
    logic       div_start;   // start divider
    logic       push_num;    // push input number
    logic       push_res;    // push arithmetic result
    logic       load_out;    // capture result item
  } rpn_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            b_zero;
    logic            div_done;
  } rpn_sts_t;

  // Clamp a 64-bit signed value to Q16.16 range.
  function automatic logic [Q_W:0] clamp_q(input logic signed [63:0] v);
    logic [Q_W:0] r;
    if (v > 64'sd2147483647)       r = {1'b1, 32'h7FFF_FFFF};
    else if (v < -64'sd2147483648) r = {1'b1, 32'h8000_0000};
    else                           r = {1'b0, v[Q_W-1:0]};
    return r;
  endfunction

endpackage

[rtl/rpn_div.sv]
// Iterative signed divider: (a << 16) / b, truncated, one quotient bit per cycle.
module rpn_div
  import rpn_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [Q_W-1:0] a,
  input  logic signed [Q_W-1:0] b,
  output logic                 done,
  output logic signed [63:0]   quot
);
  localparam int unsigned N_W = 48;

  logic [N_W-1:0] num_r, num_nxt;
  logic [Q_W:0]   rem_r, rem_nxt;
  logic [Q_W-1:0] den_r, den_nxt;
  logic           neg_r, neg_nxt;
  logic [5:0]     cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [Q_W:0]   trial;
  logic [Q_W:0]   shifted;
  logic [N_W-1:0] mag_a;

  always_comb begin
    mag_a = a[Q_W-1] ? N_W'(-{{16{a[Q_W-1]}}, a}) : N_W'({16'd0, a});
    mag_a = N_W'(mag_a << 16);
    shifted = {rem_r[Q_W-1:0], num_r[N_W-1]};
    trial   = shifted - {1'b0, den_r};
    num_nxt = num_r; rem_nxt = rem_r; den_nxt = den_r; neg_nxt = neg_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0;
    if (start) begin
      num_nxt  = mag_a;
      rem_nxt  = '0;
      den_nxt  = b[Q_W-1] ? Q_W'(-b) : Q_W'(b);
      neg_nxt  = a[Q_W-1] ^ b[Q_W-1];
      cnt_nxt  = 6'(N_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[Q_W]) begin
        rem_nxt = trial;
        num_nxt = {num_r[N_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        num_nxt = {num_r[N_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign done = done_r;
  assign quot = neg_r ? -$signed({16'd0, num_r}) : $signed({16'd0, num_r});
endmodule

[rtl/rpn_datapath.sv]
// Datapath: operand stack memory, pointer, operand registers, arithmetic, result.
module rpn_datapath
  import rpn_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 128
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rpn_cmd_t              cmd,
  output rpn_sts_t              sts,
  input  logic [OP_W-1:0]       in_op,
  input  logic [Q_W-1:0]        in_num,
  output logic [Q_W-1:0]        res_shown,
  output logic [5:0]            res_flags,  // low bit up: valid,under,over,zdiv,unk,sat
  output logic [DEPTH_OUT_W-1:0] res_depth
);
  localparam int unsigned SP_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  logic [Q_W-1:0] mem [STACK_DEPTH];
  logic [Q_W-1:0] rd_r;

  logic [OP_W-1:0] op_r;
  logic [Q_W-1:0]  num_r, a_r, b_r, res_r;
  logic [SP_W-1:0] sp_r;
  logic            under_r, over_r, sat_r, rdok_r;
  logic            div_done;
  logic signed [63:0] quot;
  logic signed [63:0] prod;
  logic signed [63:0] wide;
  logic [Q_W:0]    clamped;
  logic [AW-1:0]   rd_addr;
  logic            empty, full;

  assign empty   = (sp_r == '0);
  assign full    = (sp_r == SP_W'(STACK_DEPTH));
  assign rd_addr = AW'(sp_r - SP_W'(1));

  rpn_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cmd.div_start),
    .a    (a_r),
    .b    (b_r),
    .done (div_done),
    .quot (quot)
  );

  // Product in its own register ahead of the clamp.
  always_ff @(posedge clk) begin
    prod <= $signed(a_r) * $signed(b_r);
  end

  always_comb begin
    case (op_r)
      OP_ADD:  wide = 64'($signed(a_r)) + 64'($signed(b_r));
      OP_SUB:  wide = 64'($signed(a_r)) - 64'($signed(b_r));
      OP_MUL:  wide = (prod < 0) ? -((-prod) >>> 16) : (prod >>> 16);
      default: wide = quot;
    endcase
    clamped = clamp_q(wide);
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) rd_r <= mem[rd_addr];
    if (cmd.push_num && !full) mem[AW'(sp_r)] <= num_r;
    if (cmd.push_res && !full) mem[AW'(sp_r)] <= res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r    <= '0;
      under_r <= 1'b0;
      over_r  <= 1'b0;
      sat_r   <= 1'b0;
      rdok_r  <= 1'b0;
      op_r    <= '0;
    end else begin
      if (cmd.load_in) begin
        op_r    <= in_op;
        num_r   <= in_num;
        under_r <= 1'b0;
        over_r  <= 1'b0;
        sat_r   <= 1'b0;
        a_r     <= '0;
        b_r     <= '0;
      end
      if (cmd.rd_issue) begin
        rdok_r <= !empty;
        if (empty) under_r <= 1'b1;
        else       sp_r    <= sp_r - SP_W'(1);
      end
      if (cmd.pop_b) b_r <= rdok_r ? rd_r : '0;
      if (cmd.pop_a) a_r <= rdok_r ? rd_r : '0;
      if (cmd.arith || div_done) begin
        res_r <= clamped[Q_W-1:0];
        sat_r <= clamped[Q_W];
      end
      if (cmd.push_num || cmd.push_res) begin
        if (full) over_r <= 1'b1;
        else      sp_r   <= sp_r + SP_W'(1);
      end
    end
  end

  assign sts.op       = op_r;
  assign sts.b_zero   = (b_r == '0);
  assign sts.div_done = div_done;

  assign res_shown = (op_r == OP_SHOW) ? b_r : '0;
  assign res_flags = {sat_r && (op_r != OP_SHOW), (op_r > OP_SHOW),
                      (op_r == OP_DIV) && (b_r == '0),
                      over_r, under_r, (op_r == OP_SHOW)};
  assign res_depth = DEPTH_OUT_W'(sp_r);
endmodule

[rtl/rpn_ctrl.sv]
// Controller: sequences pops, arithmetic and pushes for one token.
module rpn_ctrl
  import rpn_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_fire,
  input  logic     out_free,
  input  rpn_sts_t sts,
  output logic     in_ready,
  output rpn_cmd_t cmd
);
  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_RDB   = 11'b000_0000_0010,
    S_WB    = 11'b000_0000_0100,
    S_RDA   = 11'b000_0000_1000,
    S_WA    = 11'b000_0001_0000,
    S_MUL   = 11'b000_0010_0000,
    S_ARITH = 11'b000_0100_0000,
    S_DIV   = 11'b000_1000_0000,
    S_PUSH  = 11'b001_0000_0000,
    S_OUT   = 11'b010_0000_0000,
    S_DEC   = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  // Kick the divider in the cycle after the dividend is popped.
  logic div_kick_r;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.div_start = div_kick_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DEC;
        end
      end
      S_DEC: begin
        case (sts.op)
          OP_PUSH: begin
            cmd.push_num = 1'b1;
            state_nxt    = S_OUT;
          end
          OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SHOW: state_nxt = S_RDB;
          default: state_nxt = S_OUT;
        endcase
      end
      S_RDB: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_WB;
      end
      S_WB: begin
        cmd.pop_b = 1'b1;
        state_nxt = (sts.op == OP_SHOW) ? S_OUT : S_RDA;
      end
      S_RDA: begin
        if (sts.op == OP_DIV && sts.b_zero) state_nxt = S_OUT;
        else begin
          cmd.rd_issue = 1'b1;
          state_nxt    = S_WA;
        end
      end
      S_WA: begin
        cmd.pop_a = 1'b1;
        if (sts.op == OP_DIV) state_nxt = S_DIV;
        else if (sts.op == OP_MUL) state_nxt = S_MUL;
        else state_nxt = S_ARITH;
      end
      S_MUL:   state_nxt = S_ARITH;
      S_ARITH: begin
        cmd.arith = 1'b1;
        state_nxt = S_PUSH;
      end
      S_DIV: begin
        if (sts.div_done) state_nxt = S_PUSH;
      end
      S_PUSH: begin
        cmd.push_res = 1'b1;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      div_kick_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      div_kick_r <= (state_r == S_WA) && (sts.op == OP_DIV);
    end
  end

  assign in_ready = (state_r == S_IDLE);
endmodule

[rtl/rpn_stack_evaluator.sv]
// Top level: RPN evaluator on a bounded Q16.16 operand stack.
//
//  channel | direction | tdata fields (low bit up)               | tuser
//  in_     | in        | operation[2:0], number_value[34:3]       | -
//  out_    | out       | shown_value[31:0], shown_valid .. flags,  | -
//          |           | stack_depth[45:38]                        |
//
// Per item the controller decodes the operation, pops b and a as it needs,
// runs the arithmetic or the 48-step shift-subtract divider (divide is the
// slowest), pushes the result and loads the output. The result is registered
// on the edge that returns the controller to idle. One token at a time.
// Reset: rst_n synchronous, empties the stack; entries need no clearing.
// Stalls: a result not yet taken holds the controller in its output state,
// so in_tready stays low until the output register frees up.
module rpn_stack_evaluator
  import rpn_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // operation[2:0], number_value[34:3], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // shown_value[31:0], shown_valid, underflow,
                                  // overflow, zero_divisor, unknown, saturated,
                                  // stack_depth[45:38], zero pad
);
  rpn_cmd_t cmd;
  rpn_sts_t sts;
  logic     in_fire, out_free;
  logic [Q_W-1:0] res_shown;
  logic [5:0]     res_flags;
  logic [DEPTH_OUT_W-1:0] res_depth;

  assign in_fire  = in_tvalid && in_tready;
  // Output register is free when empty or being drained this cycle.
  assign out_free = !out_tvalid || out_tready;

  rpn_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .out_free(out_free),
    .sts     (sts),
    .in_ready(in_tready),
    .cmd     (cmd)
  );

  rpn_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_op    (in_tdata[2:0]),
    .in_num   (in_tdata[34:3]),
    .res_shown(res_shown),
    .res_flags(res_flags),
    .res_depth(res_depth)
  );

  // Output register: hold until taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else begin
      if (cmd.load_out)                  out_tvalid <= 1'b1;
      else if (out_tvalid && out_tready) out_tvalid <= 1'b0;
    end
    if (cmd.load_out)
      out_tdata <= {2'b00, res_depth, res_flags, res_shown};
  end
endmodule

[rtl/rpn_checker.sv]
// Port checker for the RPN evaluator, bound to the top level.
module rpn_checker #(
  parameter int unsigned STACK_DEPTH = 128
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while busy");

  a_show_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[32] |-> out_tdata[31:0] == 32'd0)
    else $error("shown value nonzero without show");

  a_depth_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> 32'(out_tdata[45:38]) <= STACK_DEPTH)
    else $error("depth out of range");
endmodule

bind rpn_stack_evaluator rpn_checker #(.STACK_DEPTH(STACK_DEPTH)) u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
